// ===== design/vdir_pkg.sv =====
package vdir_pkg;

  localparam int TABLE_SLOTS_DEF = 4096;
  localparam int EPOCH_W = 8;
  localparam int KEY_BITS = 384;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int IDX_CAP = 4096;

  typedef struct packed {
    logic        first_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [63:0] uv_pair;
    logic [31:0] tan_x;
    logic [31:0] tan_y;
    logic [31:0] tan_z;
    logic [31:0] tan_w;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] new_index;
    logic             is_new;
    logic [CNT_W-1:0] unique_count;
    logic             overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP
  } state_t;

endpackage

// ===== design/vertex_dedup_index_remap.sv =====
// Vertex deduplication with compact index remapping.
// An item is taken at a rising edge where start is high and busy is low; it
// carries the quantized attributes of one referenced vertex and a first-of-mesh
// flag that starts a new mesh. Each item produces one result, shown on out_data
// for exactly one cycle while out_strobe is high; the receiver cannot stall it.
// The result gives the compact index, a new-vertex flag, the distinct count so
// far and an overflow flag for a new vertex that found the table full.
// Each item probes slots of the open-addressed table in turn; each probe is
// one read of the slot memories and one compare. A lightly loaded table
// usually needs a single probe. The next item can be accepted at the earliest
// in the cycle the result is shown.
// Slot validity is an epoch tag stored beside each compact index. After reset,
// and whenever the epoch counter wraps at a new mesh, a clearing pass writes
// every slot tag, one slot a cycle, with busy high.
module vertex_dedup_index_remap #(
  parameter int TABLE_SLOTS = vdir_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  vdir_pkg::in_t  in_data,
  output logic           out_strobe,
  output vdir_pkg::out_t out_data
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int NCH = (vdir_pkg::KEY_BITS + SLOT_W - 1) / SLOT_W;
  localparam int CAP = (TABLE_SLOTS < vdir_pkg::IDX_CAP) ? TABLE_SLOTS : vdir_pkg::IDX_CAP;
  localparam int TAG_W = vdir_pkg::EPOCH_W + vdir_pkg::IDX_W;
  localparam logic [vdir_pkg::CNT_W-1:0] CAP_C = vdir_pkg::CNT_W'(CAP);
  localparam logic [SLOT_W:0] SLOTS_C = (SLOT_W+1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [vdir_pkg::KEY_BITS-1:0] key_mem [TABLE_SLOTS];
  logic [TAG_W-1:0]              tag_mem [TABLE_SLOTS];

  vdir_pkg::state_t state_r, state_nxt;
  logic [vdir_pkg::KEY_BITS-1:0] key_r, key_nxt, key_rd_r;
  logic [TAG_W-1:0]              tag_rd_r;
  logic [SLOT_W-1:0]             slot_r, slot_nxt, slot_inc;
  logic [SLOT_W:0]               probe_r, probe_nxt, probe_inc;
  logic [vdir_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [vdir_pkg::EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic                          pend_r, pend_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  vdir_pkg::out_t                out_r, out_nxt;
  logic                          wr_en, rd_en;
  logic [TAG_W-1:0]              tag_wd;
  logic                          hit_valid, hit_key, accept;
  logic [NCH*SLOT_W-1:0]         key_pad;
  logic [SLOT_W-1:0]             fold;
  logic [SLOT_W:0]               fold_ext;

  assign busy = (state_r != vdir_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_data = out_r;
  assign hit_valid = (tag_rd_r[TAG_W-1 -: vdir_pkg::EPOCH_W] == epoch_r);
  assign hit_key = (key_rd_r == key_r);
  assign slot_inc = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign probe_inc = probe_r + 1'b1;

  always_comb begin
    key_pad = (NCH*SLOT_W)'(key_r);
    fold = '0;
    for (int i = 0; i < NCH; i++) begin
      fold = fold ^ key_pad[i*SLOT_W +: SLOT_W];
    end
    fold_ext = {1'b0, fold};
    if (fold_ext >= SLOTS_C) begin
      fold_ext = fold_ext - SLOTS_C;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdir_pkg::ST_CLEAR: begin
        if (slot_r == LAST_SLOT) begin
          state_nxt = pend_r ? vdir_pkg::ST_HASH : vdir_pkg::ST_IDLE;
        end
      end
      vdir_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.first_of_mesh && (epoch_r == '1)) begin
            state_nxt = vdir_pkg::ST_CLEAR;
          end else begin
            state_nxt = vdir_pkg::ST_HASH;
          end
        end
      end
      vdir_pkg::ST_HASH: state_nxt = vdir_pkg::ST_READ;
      vdir_pkg::ST_READ: state_nxt = vdir_pkg::ST_CMP;
      vdir_pkg::ST_CMP: begin
        if (!hit_valid || hit_key || (probe_inc == SLOTS_C)) begin
          state_nxt = vdir_pkg::ST_IDLE;
        end else begin
          state_nxt = vdir_pkg::ST_READ;
        end
      end
      default: state_nxt = vdir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    key_nxt = key_r;
    slot_nxt = slot_r;
    probe_nxt = probe_r;
    count_nxt = count_r;
    epoch_nxt = epoch_r;
    pend_nxt = pend_r;
    out_strobe_nxt = 1'b0;
    out_nxt = out_r;
    wr_en = 1'b0;
    rd_en = 1'b0;
    tag_wd = {{vdir_pkg::EPOCH_W{1'b0}}, count_r[vdir_pkg::IDX_W-1:0]};
    unique case (state_r)
      vdir_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        tag_wd = '0;
        slot_nxt = slot_inc;
      end
      vdir_pkg::ST_IDLE: begin
        if (accept) begin
          key_nxt = {in_data.pos_y, in_data.pos_x, in_data.norm_x, in_data.pos_z,
                     in_data.norm_z, in_data.norm_y, in_data.uv_pair,
                     in_data.tan_y, in_data.tan_x, in_data.tan_w, in_data.tan_z};
          slot_nxt = '0;
          if (in_data.first_of_mesh) begin
            count_nxt = '0;
            if (epoch_r == '1) begin
              epoch_nxt = vdir_pkg::EPOCH_W'(1);
              pend_nxt = 1'b1;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      vdir_pkg::ST_HASH: begin
        pend_nxt = 1'b0;
        slot_nxt = fold_ext[SLOT_W-1:0];
        probe_nxt = '0;
      end
      vdir_pkg::ST_READ: rd_en = 1'b1;
      vdir_pkg::ST_CMP: begin
        if (!hit_valid) begin
          out_strobe_nxt = 1'b1;
          if (count_r < CAP_C) begin
            wr_en = 1'b1;
            tag_wd = {epoch_r, count_r[vdir_pkg::IDX_W-1:0]};
            count_nxt = count_r + 1'b1;
            out_nxt.new_index = count_r[vdir_pkg::IDX_W-1:0];
            out_nxt.is_new = 1'b1;
            out_nxt.unique_count = count_r + 1'b1;
            out_nxt.overflow = 1'b0;
          end else begin
            out_nxt.new_index = '0;
            out_nxt.is_new = 1'b0;
            out_nxt.unique_count = count_r;
            out_nxt.overflow = 1'b1;
          end
        end else if (hit_key) begin
          out_strobe_nxt = 1'b1;
          out_nxt.new_index = tag_rd_r[vdir_pkg::IDX_W-1:0];
          out_nxt.is_new = 1'b0;
          out_nxt.unique_count = count_r;
          out_nxt.overflow = 1'b0;
        end else if (probe_inc == SLOTS_C) begin
          out_strobe_nxt = 1'b1;
          out_nxt.new_index = '0;
          out_nxt.is_new = 1'b0;
          out_nxt.unique_count = count_r;
          out_nxt.overflow = 1'b1;
        end else begin
          slot_nxt = slot_inc;
          probe_nxt = probe_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdir_pkg::ST_CLEAR;
      slot_r <= '0;
      count_r <= '0;
      epoch_r <= vdir_pkg::EPOCH_W'(1);
      pend_r <= 1'b0;
      out_strobe_r <= 1'b0;
      probe_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      count_r <= count_nxt;
      epoch_r <= epoch_nxt;
      pend_r <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[slot_r] <= tag_wd;
      if (state_r == vdir_pkg::ST_CMP) begin
        key_mem[slot_r] <= key_r;
      end
    end
    if (rd_en) begin
      tag_rd_r <= tag_mem[slot_r];
      key_rd_r <= key_mem[slot_r];
    end
  end

endmodule
